@@ sv/interval_union_cover_set_top_assert.svh @@
// Assertion macros for the interval union cover set block.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef INTERVAL_UNION_COVER_SET_TOP_ASSERT_SVH
`define INTERVAL_UNION_COVER_SET_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IUCS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define IUCS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define IUCS_ASSERT_IMP(lbl, ante, cons)
`define IUCS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ sv/iucs_pkg.sv @@
`timescale 1ns / 1ps
package iucs_pkg;
	localparam int MAX_SPANS  = 64;
	localparam int COORD_BITS = 51;
	localparam int IDX_W      = $clog2(MAX_SPANS);
	localparam int CNT_W      = $clog2(MAX_SPANS + 1);
	localparam int ENTRY_W    = 2 * COORD_BITS;

	// controller -> datapath
	typedef struct packed {
		logic load;   // take input beat
		logic eval;   // process entry read last cycle
		logic fin;    // close item, post result
	} iucs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_end;
		logic out_free;
	} iucs_stat_t;
endpackage

@@ sv/interval_union_cover_set_top.sv @@
`timescale 1ns / 1ps
// channel | dir | beat contents
// s_*     | in  | tuser: cmd (0 query, 1 insert); tdata: lo[50:0], hi[101:51], 2 zero bits
// m_*     | out | tdata: covered[0], overflow[1], span_count[8:2], 7 zero bits
//
// Steps: an item is accepted in IDLE, then passes ISSUE and EVAL for each of the
// v entries visited (at most n+1 for an insert over n spans), and FINAL posts its
// result; no new input is taken until the item is back in IDLE. ISSUE reads an
// entry from the span RAM, and EVAL works on that registered read.
// Reset: arst_n clears the store (count to zero) at once; no clearing pass.
// Stalls: a finished result waits in the output register; the next beat is
// taken meanwhile, and an item only holds at its end while that register is full.
module interval_union_cover_set_top import iucs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic         s_tuser,   // cmd
	input  logic [103:0] s_tdata,   // lo, hi, pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [15:0]  m_tdata    // covered, overflow, span_count, pad
);
	iucs_cmd_t  cmd;
	iucs_stat_t stat;
	logic             covered, overflow;
	logic [CNT_W-1:0] span_count;

	iucs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.stat(stat), .cmd(cmd)
	);

	// datapath: two span banks, scan/compact counters, result register
	iucs_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_cmd(s_tuser),
		.in_lo(s_tdata[COORD_BITS-1:0]),
		.in_hi(s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.covered(covered), .overflow(overflow), .span_count(span_count)
	);

	assign m_tdata = {7'd0, span_count, overflow, covered};
endmodule

@@ sv/iucs_ram.sv @@
`timescale 1ns / 1ps
module iucs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ sv/iucs_ctrl.sv @@
`timescale 1ns / 1ps
module iucs_ctrl import iucs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  iucs_stat_t stat,
	output iucs_cmd_t  cmd
);
	typedef enum logic [1:0] {IDLE, ISSUE, EVAL, FINAL} state_t;
	state_t state_q;

	assign s_tready = (state_q == IDLE);
	assign cmd.load = s_tvalid && (state_q == IDLE);
	assign cmd.eval = (state_q == EVAL);
	assign cmd.fin  = (state_q == FINAL) && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			case (state_q)
				IDLE:  if (s_tvalid) state_q <= ISSUE;
				ISSUE: state_q <= stat.scan_end ? FINAL : EVAL;
				EVAL:  state_q <= ISSUE;
				FINAL: if (stat.out_free) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

@@ sv/iucs_dp.sv @@
`timescale 1ns / 1ps
`include "interval_union_cover_set_top_assert.svh"
module iucs_dp import iucs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  iucs_cmd_t             cmd,
	output iucs_stat_t            stat,
	input  logic                  in_cmd,
	input  logic [COORD_BITS-1:0] in_lo,
	input  logic [COORD_BITS-1:0] in_hi,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  covered,
	output logic                  overflow,
	output logic [CNT_W-1:0]      span_count
);
	logic                  bank_q;    // bank holding the live store
	logic [CNT_W-1:0]      cnt_q, rd_q, wr_q;
	logic                  ins_q, stop_q, found_q, emit_q;
	logic [COORD_BITS-1:0] lo_q, hi_q, nlo_q, nhi_q, e_q;
	logic                  out_valid_q, cov_q, ovf_q;
	logic [CNT_W-1:0]      out_cnt_q;

	logic [ENTRY_W-1:0]    rdata0, rdata1, rdata;
	logic [COORD_BITS-1:0] st, en;
	logic                  we;
	logic [CNT_W-1:0]      waddr;
	logic [ENTRY_W-1:0]    wdata;
	logic                  is_left, merge, emit_now;
	logic [CNT_W-1:0]      newn;
	logic                  refuse;

	assign rdata = bank_q ? rdata1 : rdata0;
	assign st    = rdata[COORD_BITS-1:0];
	assign en    = rdata[ENTRY_W-1:COORD_BITS];

	assign is_left  = en < lo_q;
	assign merge    = !is_left && (st <= hi_q);
	assign emit_now = !is_left && !merge && !emit_q;

	assign newn   = emit_q ? wr_q : wr_q + CNT_W'(1);
	assign refuse = newn > CNT_W'(MAX_SPANS);

	always_comb begin
		we    = 1'b0;
		waddr = wr_q;
		wdata = rdata;
		if (cmd.eval && ins_q && !merge) begin
			we = 1'b1;
			if (emit_now) wdata = {nhi_q, nlo_q};
		end else if (cmd.fin && ins_q && !emit_q) begin
			we    = 1'b1;
			wdata = {nhi_q, nlo_q};
		end
	end

	// ping-pong: scan the live bank, build the new list in the other one
	iucs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SPANS)) u_ram0 (
		.clk(clk), .we(we && bank_q), .waddr(waddr[IDX_W-1:0]), .wdata(wdata),
		.raddr(rd_q[IDX_W-1:0]), .rdata(rdata0)
	);
	iucs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SPANS)) u_ram1 (
		.clk(clk), .we(we && !bank_q), .waddr(waddr[IDX_W-1:0]), .wdata(wdata),
		.raddr(rd_q[IDX_W-1:0]), .rdata(rdata1)
	);

	assign stat.scan_end = stop_q || (rd_q == cnt_q);
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q  <= in_lo;
			hi_q  <= in_hi;
			nlo_q <= in_lo;
			nhi_q <= in_hi;
		end else if (cmd.eval && ins_q && merge) begin
			if (st < nlo_q) nlo_q <= st;
			if (en > nhi_q) nhi_q <= en;
		end
		if (cmd.eval && !ins_q && st <= lo_q) e_q <= en;
		if (cmd.fin) begin
			cov_q     <= !ins_q && found_q && (e_q >= hi_q);
			ovf_q     <= ins_q && refuse;
			out_cnt_q <= (ins_q && !refuse) ? newn : cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q      <= 1'b0;
			cnt_q       <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			ins_q       <= 1'b0;
			stop_q      <= 1'b0;
			found_q     <= 1'b0;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				rd_q    <= '0;
				wr_q    <= '0;
				ins_q   <= in_cmd && (in_lo <= in_hi);
				stop_q  <= in_cmd && (in_lo > in_hi);  // reversed insert: no-op
				found_q <= 1'b0;
				emit_q  <= 1'b0;
			end else if (cmd.eval) begin
				if (ins_q) begin
					if (!emit_now) rd_q <= rd_q + CNT_W'(1);
					if (emit_now)  emit_q <= 1'b1;
					if (!merge)    wr_q <= wr_q + CNT_W'(1);
				end else if (st <= lo_q) begin
					found_q <= 1'b1;
					rd_q    <= rd_q + CNT_W'(1);
				end else begin
					stop_q <= 1'b1;
				end
			end
			if (cmd.fin && ins_q && !refuse) begin
				bank_q <= !bank_q;
				cnt_q  <= newn;
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign covered    = cov_q;
	assign overflow   = ovf_q;
	assign span_count = out_cnt_q;

	`IUCS_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_q <= CNT_W'(MAX_SPANS))
	`IUCS_ASSERT_IMP(a_flags_excl, out_valid_q, !(cov_q && ovf_q))
	`IUCS_ASSERT_NXT(a_cnt_hold, !cmd.fin, $stable(cnt_q))
	`IUCS_ASSERT_IMP(a_wr_behind, ins_q, wr_q <= rd_q + CNT_W'(1))
endmodule
